// ===== rtl/core/mts_pkg.sv =====
// Shared types and constants for the min-tracking stack.
package mts_pkg;

  localparam int DATA_W  = 32;
  localparam int ENTRY_W = 34;

  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] NEG_ONE = -32'sd1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_FILL
  } state_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] min_value;
    logic                     is_empty;
    status_t                  status;
  } res_t;

  function automatic logic signed [ENTRY_W-1:0] sext_entry(input logic signed [DATA_W-1:0] v);
    return {{(ENTRY_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  // Build a result from the top entry and the minimum; empty reports -1 twice.
  function automatic res_t make_res(input logic                      nonempty,
                                    input logic signed [ENTRY_W-1:0] e,
                                    input logic signed [DATA_W-1:0]  mn,
                                    input status_t                   st);
    res_t r;
    r.status = st;
    if (nonempty) begin
      r.top_value = (e >= sext_entry(mn)) ? e[DATA_W-1:0] : mn;
      r.min_value = mn;
      r.is_empty  = 1'b0;
    end else begin
      r.top_value = NEG_ONE;
      r.min_value = NEG_ONE;
      r.is_empty  = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/mts_if.sv =====
// Valid/ready channel interfaces for operations and results.
interface mts_in_if import mts_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface mts_out_if import mts_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] top_value;
  logic signed [DATA_W-1:0] min_value;
  logic                     is_empty;
  status_t                  status;

  modport source (output valid, output top_value, output min_value, output is_empty,
                  output status, input ready);
  modport sink   (input valid, input top_value, input min_value, input is_empty,
                  input status, output ready);
endinterface

// ===== rtl/core/mts_store.sv =====
// Entry memory: one write port, one read port, registered read data.
module mts_store import mts_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic signed [ENTRY_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic signed [ENTRY_W-1:0] rd_data
);

  logic signed [ENTRY_W-1:0] mem [DEPTH];
  logic signed [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/mts_ctrl.sv =====
// Stack control: count, minimum, cached top entry and memory sequencing.
module mts_ctrl import mts_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int CW    = 9
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_fire,
  input  logic                      in_action,
  input  logic signed [DATA_W-1:0]  in_value,
  input  logic                      out_free,
  output logic                      in_ready,
  output logic                      res_valid,
  output res_t                      res,
  output logic                      mem_we,
  output logic [AW-1:0]             mem_waddr,
  output logic signed [ENTRY_W-1:0] mem_wdata,
  output logic                      mem_re,
  output logic [AW-1:0]             mem_raddr,
  input  logic signed [ENTRY_W-1:0] mem_rdata
);

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic signed [DATA_W-1:0]  min_r, min_nxt;
  logic signed [ENTRY_W-1:0] top_r, top_nxt;

  logic                      full;
  logic signed [ENTRY_W-1:0] enc;
  logic signed [ENTRY_W-1:0] restored;
  logic [CW-1:0]             count_dec;
  logic [CW-1:0]             count_dec2;

  assign full       = (count_r == CW'(DEPTH));
  assign enc        = {in_value[DATA_W-1], in_value, 1'b0} - sext_entry(min_r);
  assign restored   = {min_r[DATA_W-1], min_r, 1'b0} - top_r;
  assign count_dec  = count_r - CW'(1);
  assign count_dec2 = count_r - CW'(2);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_action && (count_r > CW'(1))) begin
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    min_nxt   = min_r;
    top_nxt   = top_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    res       = make_res(1'b0, top_r, min_r, ST_OK);
    mem_we    = 1'b0;
    mem_waddr = count_r[AW-1:0];
    mem_wdata = enc;
    mem_re    = 1'b0;
    mem_raddr = count_dec2[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        in_ready = out_free;
        if (in_fire) begin
          if (!in_action) begin
            if (full) begin
              res_valid = 1'b1;
              res       = make_res(1'b1, top_r, min_r, ST_FULL);
            end else begin
              if ((count_r == '0) || (in_value >= min_r)) begin
                mem_wdata = sext_entry(in_value);
                min_nxt   = (count_r == '0) ? in_value : min_r;
              end else begin
                mem_wdata = enc;
                min_nxt   = in_value;
              end
              mem_we    = 1'b1;
              top_nxt   = mem_wdata;
              count_nxt = count_r + CW'(1);
              res_valid = 1'b1;
              res       = make_res(1'b1, mem_wdata, min_nxt, ST_OK);
            end
          end else begin
            if (count_r == '0) begin
              res_valid = 1'b1;
              res       = make_res(1'b0, top_r, min_r, ST_EMPTY);
            end else begin
              if (top_r < sext_entry(min_r)) begin
                min_nxt = restored[DATA_W-1:0];
              end
              count_nxt = count_dec;
              if (count_r == CW'(1)) begin
                res_valid = 1'b1;
                res       = make_res(1'b0, top_r, min_nxt, ST_OK);
              end else begin
                mem_re = 1'b1;
              end
            end
          end
        end
      end
      S_FILL: begin
        if (out_free) begin
          top_nxt   = mem_rdata;
          res_valid = 1'b1;
          res       = make_res(1'b1, mem_rdata, min_r, ST_OK);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      min_r   <= INT_MAX;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      min_r   <= min_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
  end

endmodule

// ===== rtl/core/min_tracking_stack.sv =====
// Top level of the min-tracking stack: channel ports, control, memory, result register.
// A bounded stack of signed 32-bit values that reports its top and its minimum after
// every push or pop (both -1 when empty), plus a status: ok, push dropped when full,
// or pop ignored when empty. Entries are kept in one STACK_DEPTH x 34-bit memory;
// a push below the minimum stores an encoded entry, so no second stack is needed.
// A push, a dropped push, an ignored pop, or a pop that empties the stack answers at
// once; a pop that leaves entries goes via the fill state, as the new top comes from
// the memory's registered read port. No clearing pass after reset. The result sits in
// an output register, so the next operation is accepted while a result is being taken.
module min_tracking_stack import mts_pkg::*; #(
  parameter int STACK_DEPTH = 256
) (
  input  logic    clk,
  input  logic    rst_n,
  mts_in_if.sink    in_ch,
  mts_out_if.source out_ch
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic                      in_fire;
  logic                      out_free;
  logic                      res_valid;
  res_t                      res;
  logic                      out_valid_r;
  res_t                      out_res_r;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic signed [ENTRY_W-1:0] mem_wdata;
  logic                      mem_re;
  logic [AW-1:0]             mem_raddr;
  logic signed [ENTRY_W-1:0] mem_rdata;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  mts_ctrl #(.DEPTH(STACK_DEPTH), .AW(AW), .CW(CW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_action (in_ch.action),
    .in_value  (in_ch.value),
    .out_free  (out_free),
    .in_ready  (in_ch.ready),
    .res_valid (res_valid),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  mts_store #(.DEPTH(STACK_DEPTH), .AW(AW)) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rd_data (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.top_value = out_res_r.top_value;
  assign out_ch.min_value = out_res_r.min_value;
  assign out_ch.is_empty  = out_res_r.is_empty;
  assign out_ch.status    = out_res_r.status;

endmodule
